### rtl/core/e2p_pkg.sv
package e2p_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_ROT0   = 3'd0,
    REG_ROT1   = 3'd1,
    REG_ROT2   = 3'd2,
    REG_FOCAL  = 3'd3,
    REG_VIEW_W = 3'd4,
    REG_VIEW_H = 3'd5,
    REG_PANO_W = 3'd6,
    REG_PANO_H = 3'd7
  } reg_idx_e;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 8;
  localparam int CFG_W         = 54;

  // view vector component and rotated ray component widths
  localparam int VEC_W = 17;
  localparam int RAY_W = 38;
  // cordic datapath width, leaves headroom for gain growth
  localparam int CW    = 42;
  localparam int ANG_W = 33;

  localparam logic signed [ANG_W-1:0] HALF_TURN    = 33'sh0_8000_0000;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 33'sh0_4000_0000;
  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  typedef struct packed {
    logic [CFG_W-1:0] rot0;
    logic [CFG_W-1:0] rot1;
    logic [CFG_W-1:0] rot2;
    logic [15:0]      focal;
    logic [12:0]      view_w;
    logic [12:0]      view_h;
    logic [13:0]      pano_w;
    logic [12:0]      pano_h;
  } cfg_t;

  // one cordic lane in flight; zero marks the degenerate zero vector
  typedef struct packed {
    logic signed [CW-1:0]    x;
    logic signed [CW-1:0]    y;
    logic signed [ANG_W-1:0] ang;
    logic                    zero;
  } cord_t;

  function automatic logic signed [ANG_W-1:0] atan_turn(input int i);
    logic [31:0] t;
    case (i)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      default: t = 32'd0;
    endcase
    return signed'({1'b0, t});
  endfunction

  // entry j of a rotation row as signed q1.16
  function automatic logic signed [17:0] rot_entry(input logic [CFG_W-1:0] row,
                                                    input int j);
    return signed'(row[18*j +: 18]);
  endfunction

  // one vectoring micro-rotation; the zero vector passes through untouched
  function automatic cord_t cordic_step(input cord_t c, input int i);
    cord_t r;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    xs = c.x >>> i;
    ys = c.y >>> i;
    r  = c;
    if (!c.zero) begin
      if (!c.y[CW-1]) begin
        r.x   = c.x + ys;
        r.y   = c.y - xs;
        r.ang = c.ang + atan_turn(i);
      end else begin
        r.x   = c.x - ys;
        r.y   = c.y + xs;
        r.ang = c.ang - atan_turn(i);
      end
    end
    return r;
  endfunction

  // pre-rotation into the right half plane; zero vector gives angle zero
  function automatic cord_t cordic_init(input logic signed [CW-1:0] x,
                                        input logic signed [CW-1:0] y);
    cord_t r;
    r.x    = x;
    r.y    = y;
    r.ang  = '0;
    r.zero = (x == '0) && (y == '0);
    if (x[CW-1]) begin
      r.ang = y[CW-1] ? -HALF_TURN : HALF_TURN;
      r.x   = -x;
      r.y   = -y;
    end
    return r;
  endfunction

endpackage

### rtl/core/e2p_cordic.sv
// pipelined vectoring cordic: a half-plane fold stage, then one micro-rotation per stage
module e2p_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [e2p_pkg::CW-1:0] x_i,
  input  logic signed [e2p_pkg::CW-1:0] y_i,
  input  logic [63:0]                  side_i,
  output logic                         valid_o,
  output e2p_pkg::cord_t               res_o,
  output logic [63:0]                  side_o
);
  import e2p_pkg::*;

  cord_t       st_q   [CORDIC_STAGES+1];
  logic [63:0] side_q [CORDIC_STAGES+1];
  logic        vld_q  [CORDIC_STAGES+1];

  // stage zero: half-plane fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0]   <= cordic_init(x_i, y_i);
      side_q[0] <= side_i;
    end
  end

  // micro-rotation stages
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[g+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[g+1] <= vld_q[g];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[g+1]   <= cordic_step(st_q[g], g);
        side_q[g+1] <= side_q[g];
      end
    end
  end

  assign valid_o = vld_q[CORDIC_STAGES];
  assign res_o   = st_q[CORDIC_STAGES];
  assign side_o  = side_q[CORDIC_STAGES];

endmodule

### rtl/core/e2p_rotate.sv
// view vector times rotation matrix; centring, products and sum are each registered
module e2p_rotate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  logic [11:0]                    col_i,
  input  logic [11:0]                    row_i,
  input  e2p_pkg::cfg_t                  cfg_i,
  output logic                           valid_o,
  output logic signed [e2p_pkg::RAY_W-1:0] dx_o,
  output logic signed [e2p_pkg::RAY_W-1:0] dy_o,
  output logic signed [e2p_pkg::RAY_W-1:0] dz_o
);
  import e2p_pkg::*;

  logic signed [VEC_W-1:0] v_q [3];
  logic                    v_vld_q;
  logic signed [35:0]      p_q [3][3];
  logic                    p_vld_q;
  logic [CFG_W-1:0]        rows [3];

  assign rows[0] = cfg_i.rot0;
  assign rows[1] = cfg_i.rot1;
  assign rows[2] = cfg_i.rot2;

  // centre on the principal point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_vld_q <= 1'b0;
      p_vld_q <= 1'b0;
    end else if (en_i) begin
      v_vld_q <= valid_i;
      p_vld_q <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= signed'({5'd0, col_i}) - signed'({5'd0, cfg_i.view_w[12:1]});
      v_q[1] <= signed'({5'd0, row_i}) - signed'({5'd0, cfg_i.view_h[12:1]});
      v_q[2] <= signed'({1'b0, cfg_i.focal});
    end
  end

  // nine 18x17 products
  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[r][j] <= 36'(rot_entry(rows[r], j) * v_q[j]);
        end
      end
    end
  end

  // sum and output register
  logic signed [RAY_W-1:0] d_q [3];
  logic                    d_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      d_vld_q <= p_vld_q;
    end
  end

  for (genvar r = 0; r < 3; r++) begin : g_sum
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        d_q[r] <= RAY_W'(p_q[r][0]) + RAY_W'(p_q[r][1]) + RAY_W'(p_q[r][2]);
      end
    end
  end

  assign valid_o = d_vld_q;
  assign dx_o    = d_q[0];
  assign dy_o    = d_q[1];
  assign dz_o    = d_q[2];

endmodule

### rtl/core/e2p_place.sv
// angle to panorama index, fraction and clamp, two register stages
module e2p_place (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [e2p_pkg::ANG_W-1:0] phi_i,
  input  logic signed [e2p_pkg::ANG_W-1:0] theta_i,
  input  e2p_pkg::cfg_t                    cfg_i,
  output logic                             valid_o,
  output logic [12:0]                      pano_col_o,
  output logic [11:0]                      pano_row_o,
  output logic [7:0]                       frac_col_o,
  output logic [7:0]                       frac_row_o,
  output logic                             clamped_o
);
  import e2p_pkg::*;

  // angle offsets are at most 2^32, positions stay below 2^47
  logic signed [ANG_W:0] uc, ur;
  logic signed [48:0]    pc_q, pr_q;
  logic                  m_vld_q;

  assign uc = ANG_W'(phi_i) + (ANG_W+1)'(HALF_TURN);
  assign ur = ANG_W'(theta_i) + (ANG_W+1)'(QUARTER_TURN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= valid_i;
    end
  end

  // position scaled by 2^32 pixels
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q <= 49'(uc * signed'({1'b0, cfg_i.pano_w}));
      pr_q <= 49'(ur * signed'({1'b0, cfg_i.pano_h, 1'b0}));
    end
  end

  logic [16:0] ipc, ipr, limc, limr;
  logic        clc, clr;
  logic [12:0] idxc;
  logic [11:0] idxr;
  logic [7:0]  fc, fr;

  assign ipc  = pc_q[48:32];
  assign ipr  = pr_q[48:32];
  assign limc = (cfg_i.pano_w == '0) ? 17'd0 : 17'(cfg_i.pano_w) - 17'd1;
  assign limr = (cfg_i.pano_h == '0) ? 17'd0 : 17'(cfg_i.pano_h) - 17'd1;

  // clamp at either edge
  always_comb begin
    clc  = 1'b1;
    idxc = '0;
    fc   = '0;
    if (pc_q[48]) begin
      idxc = '0;
    end else if (ipc > limc) begin
      idxc = limc[12:0];
    end else begin
      clc  = 1'b0;
      idxc = ipc[12:0];
      fc   = 8'(pc_q[31 -: FRAC_BITS]);
    end
    clr  = 1'b1;
    idxr = '0;
    fr   = '0;
    if (pr_q[48]) begin
      idxr = '0;
    end else if (ipr > limr) begin
      idxr = limr[11:0];
    end else begin
      clr  = 1'b0;
      idxr = ipr[11:0];
      fr   = 8'(pr_q[31 -: FRAC_BITS]);
    end
  end

  logic o_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_vld_q <= 1'b0;
    end else if (en_i) begin
      o_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pano_col_o <= idxc;
      pano_row_o <= idxr;
      frac_col_o <= fc;
      frac_row_o <= fr;
      clamped_o  <= clc | clr;
    end
  end

  assign valid_o = o_vld_q;

endmodule

### rtl/core/equirect_to_perspective_coords.sv
// Maps each perspective view pixel (out_col, out_row) to an equirectangular
// panorama position with 8-bit fractions, one transaction per clock while
// the output is not stalled. The pipeline holds three stages for the matrix
// product, two 17-stage vectoring cordics (longitude, then latitude from the
// first cordic's magnitude), a gain-correction multiply and two stages for the
// index mapping. A stall on the output freezes the whole pipeline, so
// in_stall_o is high exactly while a held result is stalled and low
// otherwise; transactions can follow back to back.
// Configuration must only be written while the pipeline is empty.
module equirect_to_perspective_coords (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [53:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [11:0] out_col_i,
  input  logic [11:0] out_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] pano_col_o,
  output logic [11:0] pano_row_o,
  output logic [7:0]  frac_col_o,
  output logic [7:0]  frac_row_o,
  output logic        was_clamped_o
);
  import e2p_pkg::*;

  cfg_t cfg_q;
  logic en;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rot0   <= 54'd65536;
      cfg_q.rot1   <= 54'd65536 << 18;
      cfg_q.rot2   <= 54'd65536 << 36;
      cfg_q.focal  <= 16'd500;
      cfg_q.view_w <= 13'd640;
      cfg_q.view_h <= 13'd480;
      cfg_q.pano_w <= 14'd4096;
      cfg_q.pano_h <= 13'd2048;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ROT0:   cfg_q.rot0   <= cfg_data_i;
        REG_ROT1:   cfg_q.rot1   <= cfg_data_i;
        REG_ROT2:   cfg_q.rot2   <= cfg_data_i;
        REG_FOCAL:  cfg_q.focal  <= cfg_data_i[15:0];
        REG_VIEW_W: cfg_q.view_w <= cfg_data_i[12:0];
        REG_VIEW_H: cfg_q.view_h <= cfg_data_i[12:0];
        REG_PANO_W: cfg_q.pano_w <= cfg_data_i[13:0];
        REG_PANO_H: cfg_q.pano_h <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // pipeline advances unless a held result is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic                    r_vld;
  logic signed [RAY_W-1:0] dx, dy, dz;

  e2p_rotate u_rotate (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .col_i(out_col_i), .row_i(out_row_i), .cfg_i(cfg_q),
    .valid_o(r_vld), .dx_o(dx), .dy_o(dy), .dz_o(dz)
  );

  // longitude cordic, dy rides along
  logic        c1_vld;
  cord_t       c1;
  logic [63:0] c1_side;

  e2p_cordic u_lon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(r_vld),
    .x_i(CW'(dz)), .y_i(CW'(dx)), .side_i(64'(dy)),
    .valid_o(c1_vld), .res_o(c1), .side_o(c1_side)
  );

  // gain correction of the magnitude
  logic signed [CW-1:0]    hyp_q;
  logic signed [RAY_W-1:0] dy_q;
  logic signed [ANG_W-1:0] phi_q;
  logic                    g_vld_q;
  logic signed [CW+17:0]   hp;

  assign hp = c1.x * signed'({1'b0, INV_GAIN_Q16});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (en) begin
      g_vld_q <= c1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hyp_q <= CW'(hp >>> 16);
      dy_q  <= RAY_W'(c1_side);
      phi_q <= c1.ang;
    end
  end

  // latitude cordic, longitude rides along
  logic        c2_vld;
  cord_t       c2;
  logic [63:0] c2_side;

  e2p_cordic u_lat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_vld_q),
    .x_i(hyp_q), .y_i(CW'(dy_q)), .side_i(64'(phi_q)),
    .valid_o(c2_vld), .res_o(c2), .side_o(c2_side)
  );

  e2p_place u_place (
    .clk_i, .rst_ni, .en_i(en), .valid_i(c2_vld),
    .phi_i(ANG_W'(c2_side)), .theta_i(c2.ang), .cfg_i(cfg_q),
    .valid_o(out_valid_o), .pano_col_o, .pano_row_o, .frac_col_o, .frac_row_o,
    .clamped_o(was_clamped_o)
  );

endmodule

### dv/tb_equirect_to_perspective_coords.sv
module tb_equirect_to_perspective_coords;
  timeunit 1ns;
  timeprecision 1ps;

  import e2p_pkg::*;

  // one panorama position as the block reports it
  typedef struct packed {
    logic [12:0] pano_col;
    logic [11:0] pano_row;
    logic [7:0]  frac_col;
    logic [7:0]  frac_row;
    logic        was_clamped;
  } pano_pos_t;

  // expected panorama positions, worked out from the view pixel and the settings
  class pano_scoreboard;
    pano_pos_t  pending_q[$];
    int         n_errors;
    logic [53:0] rot[3];
    longint     focal, view_w, view_h, pano_w, pano_h;
    longint     atan_tab[16] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861};

    function new();
      rot[0] = 54'd65536;
      rot[1] = 54'd65536 << 18;
      rot[2] = 54'd65536 << 36;
      focal  = 500;
      view_w = 640;
      view_h = 480;
      pano_w = 4096;
      pano_h = 2048;
      n_errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [53:0] val);
      case (idx)
        REG_ROT0:   rot[0] = val;
        REG_ROT1:   rot[1] = val;
        REG_ROT2:   rot[2] = val;
        REG_FOCAL:  focal  = longint'(val[15:0]);
        REG_VIEW_W: view_w = longint'(val[12:0]);
        REG_VIEW_H: view_h = longint'(val[12:0]);
        REG_PANO_W: pano_w = longint'(val[13:0]);
        REG_PANO_H: pano_h = longint'(val[12:0]);
        default: ;
      endcase
    endfunction

    // vectoring angle in q32 turns with gain-corrected magnitude
    function longint vector_angle(longint y, longint x, output longint mag);
      longint ang, xs, ys;
      ang = 0;
      mag = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        ang = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          ang += atan_tab[i];
        end else begin
          x = x - ys;
          y = y + xs;
          ang -= atan_tab[i];
        end
      end
      mag = (x * 39797) >>> 16;
      return ang;
    endfunction

    // floor, clamp and fraction of a position scaled by 2^32
    function bit place(longint pos, longint size, output longint idx, output logic [7:0] fr);
      longint lim, ip;
      lim = (size > 0) ? size - 1 : 0;
      fr  = '0;
      if (pos < 0) begin
        idx = 0;
        return 1'b1;
      end
      ip = pos >>> 32;
      if (ip > lim) begin
        idx = lim;
        return 1'b1;
      end
      idx = ip;
      fr  = pos[31:24];
      return 1'b0;
    endfunction

    function void note_pixel(logic [11:0] col, logic [11:0] row);
      longint v[3], d[3], hyp, unused, phi, theta, pc, pr, ent;
      logic [7:0] fc, fr;
      bit cl;
      pano_pos_t p;
      v[0] = longint'(col) - (view_w >> 1);
      v[1] = longint'(row) - (view_h >> 1);
      v[2] = focal;
      for (int r = 0; r < 3; r++) begin
        d[r] = 0;
        for (int j = 0; j < 3; j++) begin
          ent = longint'($signed(rot[r][18*j +: 18]));
          d[r] += ent * v[j];
        end
      end
      phi   = vector_angle(d[0], d[2], hyp);
      theta = vector_angle(d[1], hyp, unused);
      cl  = place((phi + 64'sd2147483648) * pano_w, pano_w, pc, fc);
      cl |= place((theta + 64'sd1073741824) * 2 * pano_h, pano_h, pr, fr);
      p.pano_col    = pc[12:0];
      p.pano_row    = pr[11:0];
      p.frac_col    = fc;
      p.frac_row    = fr;
      p.was_clamped = cl;
      pending_q.push_back(p);
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      n_errors++;
    endtask

    task check_position(pano_pos_t got);
      pano_pos_t exp_p;
      if (pending_q.size() == 0) begin
        report("result with no transaction outstanding");
        return;
      end
      exp_p = pending_q.pop_front();
      if (got.pano_col !== exp_p.pano_col)
        report($sformatf("pano_col %0d, want %0d", got.pano_col, exp_p.pano_col));
      if (got.pano_row !== exp_p.pano_row)
        report($sformatf("pano_row %0d, want %0d", got.pano_row, exp_p.pano_row));
      if (got.frac_col !== exp_p.frac_col)
        report($sformatf("frac_col %0d, want %0d", got.frac_col, exp_p.frac_col));
      if (got.frac_row !== exp_p.frac_row)
        report($sformatf("frac_row %0d, want %0d", got.frac_row, exp_p.frac_row));
      if (got.was_clamped !== exp_p.was_clamped)
        report($sformatf("was_clamped %0b, want %0b", got.was_clamped, exp_p.was_clamped));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [53:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [11:0] out_col_i = '0;
  logic [11:0] out_row_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [12:0] pano_col_o;
  logic [11:0] pano_row_o;
  logic [7:0]  frac_col_o;
  logic [7:0]  frac_row_o;
  logic        was_clamped_o;

  pano_scoreboard sb = new();
  bit quiet = 1'b0;

  equirect_to_perspective_coords u_dut (.*);

  // clock and reset
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_pixel(out_col_i, out_row_i);
      if (out_valid_o && !out_stall_i)
        sb.check_position({pano_col_o, pano_row_o, frac_col_o, frac_row_o, was_clamped_o});
    end
  end

  // receiver stalls in random bursts
  initial begin
    int  n;
    bit  st;
    @(posedge rst_ni);
    forever begin
      n  = $urandom_range(1, 15);
      st = ($urandom_range(0, 3) == 0) && !quiet;
      repeat (n) begin
        out_stall_i <= st && !quiet;
        @(posedge clk_i);
      end
    end
  end

  // limit on the whole run
  initial begin
    #3ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_pixel(logic [11:0] col, logic [11:0] row);
    in_valid_i <= 1'b1;
    out_col_i  <= col;
    out_row_i  <= row;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (45) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [53:0] vals[8]);
    for (int i = 0; i < 8; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= vals[i];
      sb.set_reg(reg_idx_e'(i), vals[i]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [53:0] rot_row(int a, int b, int c);
    logic [17:0] ea, eb, ec;
    ea = 18'(a);
    eb = 18'(b);
    ec = 18'(c);
    return {ec, eb, ea};
  endfunction

  function automatic logic [53:0] random_row();
    return 54'({$urandom, $urandom});
  endfunction

  // stimulus
  initial begin
    logic [53:0] cfg[8];
    @(posedge rst_ni);
    @(posedge clk_i);

    // reset settings: corners, principal point, field extremes
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    drain();

    for (int ph = 1; ph <= 8; ph++) begin
      case (ph)
        1: begin
          // zero matrix gives a zero ray; largest sizes
          cfg = '{54'd0, 54'd0, 54'd0, 54'd65535, 54'd4096, 54'd4096, 54'd8192, 54'd4096};
        end
        2: begin
          // ray pointing backwards, smallest sizes
          cfg = '{rot_row(65536, 0, 0), rot_row(0, 65536, 0), rot_row(0, 0, -65536),
                  54'd1, 54'd1, 54'd1, 54'd1, 54'd1};
        end
        3: begin
          // extreme matrix entries, empty panorama
          cfg = '{rot_row(-131072, 131071, -131072), rot_row(131071, -131072, 131071),
                  rot_row(-131072, -131072, 131071), 54'd65535, 54'd4096, 54'd1,
                  54'd0, 54'd0};
        end
        default: begin
          for (int k = 0; k < 3; k++) cfg[k] = random_row();
          cfg[3] = 54'($urandom_range(1, 65535));
          cfg[4] = 54'($urandom_range(1, 4096));
          cfg[5] = 54'($urandom_range(1, 4096));
          cfg[6] = 54'($urandom_range(1, 8192));
          cfg[7] = 54'($urandom_range(1, 4096));
          if (ph == 5) cfg = '{rot_row(65536, 0, 0), rot_row(0, 65536, 0),
                              rot_row(0, 0, 65536), cfg[3], cfg[4], cfg[5], cfg[6], cfg[7]};
          if (ph == 6) begin
            cfg[3] = 54'($urandom_range(1, 64));
            cfg[6] = {$urandom} & 54'h3FFF;
            cfg[7] = {$urandom} & 54'h1FFF;
          end
        end
      endcase
      write_settings(cfg);
      if (ph == 8) quiet = 1'b1;
      if (ph <= 3) begin
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd2048);
      end
      repeat (ph <= 3 ? 100 : 220) begin
        if ($urandom_range(0, 3) == 0)
          send_pixel(12'($urandom), 12'($urandom));
        else
          send_pixel(12'($urandom_range(0, cfg[4][12:0])), 12'($urandom_range(0, cfg[5][12:0])));
      end
      drain();
    end

    if (sb.n_errors == 0 && sb.pending_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
